// ===== src/bfsp_pkg.sv =====
// shared constants, opcodes and controller/datapath interface types
// for the shortest-path core; no dependencies
package bfsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    // fixed field widths of the ports
    localparam int OPC_W   = 2;
    localparam int VID_W   = 6;
    localparam int WIN_W   = 16;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 7;

    // derived internal widths
    localparam int V_W     = $clog2(MAX_VERTICES);
    localparam int N_W     = $clog2(MAX_VERTICES + 1);
    localparam int E_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W  = 2 * VID_W + WEIGHT_BITS;
    localparam int DENT_W  = DIST_W + 1;

    localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPC_W-1:0] OP_RUN = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLR = 2'd2;

    typedef struct packed {
        logic           edge_wr;
        logic           count_clr;
        logic           run_start;
        logic           init_wr;
        logic [V_W-1:0] addr_k;
        logic           edge_rd;
        logic [E_W-1:0] edge_addr;
        logic           rd_from;
        logic           rd_to;
        logic           cap_du;
        logic           cap_dv;
        logic           fwd_sum;
        logic           fwd_upd;
        logic           rev_sum;
        logic           rev_upd;
        logic           out_rd;
        logic           out_cap;
    } bfsp_cmd_t;

    typedef struct packed {
        logic [N_W-1:0]   n_run;
        logic [CNT_W-1:0] edge_count;
    } bfsp_stat_t;

    // signed add saturated to the distance range
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        logic [DIST_W-1:0] r;
        s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
        if (s[DIST_W] != s[DIST_W-1])
        begin
            r = s[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end
        else
        begin
            r = s[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/bfsp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bfsp_dpath.sv =====
// datapath: edge store, distance store, relaxation arithmetic, result register
// depends on bfsp_pkg and bfsp_ram
module bfsp_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bfsp_pkg::bfsp_cmd_t              cmd,
    output bfsp_pkg::bfsp_stat_t             stat,
    input  logic                             cfg_wr,
    input  logic [bfsp_pkg::CFG_W-1:0]       cfg_data,
    input  logic [bfsp_pkg::VID_W-1:0]       edge_from,
    input  logic [bfsp_pkg::VID_W-1:0]       edge_to,
    input  logic signed [bfsp_pkg::WIN_W-1:0] edge_weight,
    input  logic [bfsp_pkg::VID_W-1:0]       source_vertex,
    output logic [bfsp_pkg::VID_W-1:0]       vertex_index,
    output logic                             reachable,
    output logic signed [bfsp_pkg::DIST_W-1:0] distance,
    output logic                             last
);

    localparam int DW = bfsp_pkg::DIST_W;

    logic [bfsp_pkg::CFG_W-1:0] nv_reg;
    logic [bfsp_pkg::CNT_W-1:0] count_reg;
    logic [bfsp_pkg::N_W-1:0]   n_reg;
    logic [bfsp_pkg::VID_W-1:0] src_reg;

    logic [bfsp_pkg::CFG_W-1:0] n_eff;
    logic                       src_ok;

    logic                        e_we;
    logic [bfsp_pkg::EDGE_W-1:0] e_rdata;
    logic [bfsp_pkg::VID_W-1:0]  e_from, e_to;
    logic [bfsp_pkg::WEIGHT_BITS-1:0] e_wraw;
    logic [DW-1:0]               e_w;
    logic                        in_range;

    logic                        d_we, d_re;
    logic [bfsp_pkg::V_W-1:0]    d_waddr, d_raddr;
    logic [bfsp_pkg::DENT_W-1:0] d_wdata, d_rdata;

    logic          du_valid_reg, dv_valid_reg;
    logic [DW-1:0] du_reg, dv_reg;
    logic [DW-1:0] sum_reg;
    logic          upd_reg;
    logic [DW-1:0] sum_fwd, sum_rev;

    // clamp vertex count to 1..MAX_VERTICES
    always_comb
    begin
        if (nv_reg == '0)
        begin
            n_eff = bfsp_pkg::CFG_W'(1);
        end
        else if (nv_reg > bfsp_pkg::CFG_W'(bfsp_pkg::MAX_VERTICES))
        begin
            n_eff = bfsp_pkg::CFG_W'(bfsp_pkg::MAX_VERTICES);
        end
        else
        begin
            n_eff = nv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg    <= bfsp_pkg::CFG_W'(bfsp_pkg::MAX_VERTICES);
            count_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                nv_reg <= cfg_data;
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (e_we)
            begin
                count_reg <= count_reg + bfsp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run_start)
        begin
            n_reg   <= bfsp_pkg::N_W'(n_eff);
            src_reg <= source_vertex;
        end
    end

    assign stat.n_run      = n_reg;
    assign stat.edge_count = count_reg;

    // edge store
    assign e_we = cmd.edge_wr && (count_reg < bfsp_pkg::CNT_W'(bfsp_pkg::MAX_EDGES));

    bfsp_ram #(
        .WIDTH (bfsp_pkg::EDGE_W),
        .DEPTH (bfsp_pkg::MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (count_reg[bfsp_pkg::E_W-1:0]),
        .wdata ({edge_from, edge_to, edge_weight[bfsp_pkg::WEIGHT_BITS-1:0]}),
        .re    (cmd.edge_rd),
        .raddr (cmd.edge_addr),
        .rdata (e_rdata)
    );

    assign e_from = e_rdata[bfsp_pkg::EDGE_W-1 -: bfsp_pkg::VID_W];
    assign e_to   = e_rdata[bfsp_pkg::WEIGHT_BITS+bfsp_pkg::VID_W-1 -: bfsp_pkg::VID_W];
    assign e_wraw = e_rdata[bfsp_pkg::WEIGHT_BITS-1:0];
    assign e_w    = DW'($signed(e_wraw));

    assign in_range = (bfsp_pkg::CFG_W'(e_from) < bfsp_pkg::CFG_W'(n_reg))
                   && (bfsp_pkg::CFG_W'(e_to) < bfsp_pkg::CFG_W'(n_reg));
    assign src_ok   = bfsp_pkg::CFG_W'(src_reg) < bfsp_pkg::CFG_W'(n_reg);

    // distance store: {valid, value}
    always_comb
    begin
        d_we    = 1'b0;
        d_waddr = cmd.addr_k;
        d_wdata = {1'b0, sum_reg};
        if (cmd.init_wr)
        begin
            d_we    = 1'b1;
            d_wdata = {src_ok && (cmd.addr_k == src_reg[bfsp_pkg::V_W-1:0]), {DW{1'b0}}};
        end
        else if (cmd.fwd_upd)
        begin
            d_we    = upd_reg;
            d_waddr = e_to[bfsp_pkg::V_W-1:0];
            d_wdata = {1'b1, sum_reg};
        end
        else if (cmd.rev_upd)
        begin
            d_we    = upd_reg;
            d_waddr = e_from[bfsp_pkg::V_W-1:0];
            d_wdata = {1'b1, sum_reg};
        end
    end

    always_comb
    begin
        d_re    = cmd.rd_from || cmd.rd_to || cmd.out_rd;
        d_raddr = cmd.addr_k;
        if (cmd.rd_from)
        begin
            d_raddr = e_from[bfsp_pkg::V_W-1:0];
        end
        else if (cmd.rd_to)
        begin
            d_raddr = e_to[bfsp_pkg::V_W-1:0];
        end
    end

    bfsp_ram #(
        .WIDTH (bfsp_pkg::DENT_W),
        .DEPTH (bfsp_pkg::MAX_VERTICES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // relaxation
    assign sum_fwd = bfsp_pkg::sat_add(du_reg, e_w);
    assign sum_rev = bfsp_pkg::sat_add(dv_reg, e_w);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_du)
        begin
            du_valid_reg <= d_rdata[DW];
            du_reg       <= d_rdata[DW-1:0];
        end
        if (cmd.cap_dv)
        begin
            dv_valid_reg <= d_rdata[DW];
            dv_reg       <= d_rdata[DW-1:0];
        end
        if (cmd.fwd_sum)
        begin
            sum_reg <= sum_fwd;
            upd_reg <= in_range && du_valid_reg
                    && (!dv_valid_reg || ($signed(sum_fwd) < $signed(dv_reg)));
        end
        if (cmd.rev_sum)
        begin
            sum_reg <= sum_rev;
            upd_reg <= in_range && dv_valid_reg
                    && (!du_valid_reg || ($signed(sum_rev) < $signed(du_reg)));
        end
        if (cmd.fwd_upd && upd_reg)
        begin
            // keep local copies coherent; a self loop updates both
            dv_valid_reg <= 1'b1;
            dv_reg       <= sum_reg;
            if (e_from == e_to)
            begin
                du_valid_reg <= 1'b1;
                du_reg       <= sum_reg;
            end
        end
        if (cmd.out_cap)
        begin
            vertex_index <= bfsp_pkg::VID_W'(cmd.addr_k);
            reachable    <= d_rdata[DW];
            distance     <= d_rdata[DW] ? d_rdata[DW-1:0] : {DW{1'b1}};
            last         <= (bfsp_pkg::N_W'(cmd.addr_k) == n_reg - bfsp_pkg::N_W'(1));
        end
    end

endmodule

// ===== src/bfsp_ctrl.sv =====
// controller: sequences clearing, edge passes and result delivery
// depends on bfsp_pkg
module bfsp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bfsp_pkg::OPC_W-1:0]  opcode,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  bfsp_pkg::bfsp_stat_t        stat,
    output bfsp_pkg::bfsp_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_E_RD   = 4'd2;
    localparam logic [3:0] S_E_WAIT = 4'd3;
    localparam logic [3:0] S_D_A    = 4'd4;
    localparam logic [3:0] S_D_B    = 4'd5;
    localparam logic [3:0] S_F_SUM  = 4'd6;
    localparam logic [3:0] S_F_UPD  = 4'd7;
    localparam logic [3:0] S_R_SUM  = 4'd8;
    localparam logic [3:0] S_R_UPD  = 4'd9;
    localparam logic [3:0] S_O_RD   = 4'd10;
    localparam logic [3:0] S_O_CAP  = 4'd11;
    localparam logic [3:0] S_O_SEND = 4'd12;

    logic [3:0]               state_reg, state_next;
    logic [bfsp_pkg::V_W-1:0] k_reg, k_next;
    logic [bfsp_pkg::E_W-1:0] e_reg, e_next;
    logic [bfsp_pkg::V_W-1:0] pass_reg, pass_next;

    logic [bfsp_pkg::V_W-1:0] n_m1, n_m2;
    logic [bfsp_pkg::E_W-1:0] last_e;
    logic                     no_passes;

    assign n_m1      = bfsp_pkg::V_W'(stat.n_run - bfsp_pkg::N_W'(1));
    assign n_m2      = bfsp_pkg::V_W'(stat.n_run - bfsp_pkg::N_W'(2));
    assign last_e    = bfsp_pkg::E_W'(stat.edge_count - bfsp_pkg::CNT_W'(1));
    assign no_passes = (stat.n_run == bfsp_pkg::N_W'(1)) || (stat.edge_count == '0);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_O_SEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            e_reg     <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            e_reg     <= e_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        pass_next  = pass_reg;
        cmd           = '0;
        cmd.addr_k    = k_reg;
        cmd.edge_addr = e_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == bfsp_pkg::OP_ADD)
                    begin
                        cmd.edge_wr = 1'b1;
                    end
                    else if (opcode == bfsp_pkg::OP_CLR)
                    begin
                        cmd.count_clr = 1'b1;
                    end
                    else if (opcode == bfsp_pkg::OP_RUN)
                    begin
                        cmd.run_start = 1'b1;
                        k_next        = '0;
                        state_next    = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (k_reg == n_m1)
                begin
                    k_next    = '0;
                    e_next    = '0;
                    pass_next = '0;
                    state_next = no_passes ? S_O_RD : S_E_RD;
                end
                else
                begin
                    k_next = k_reg + bfsp_pkg::V_W'(1);
                end
            end
            S_E_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_E_WAIT;
            end
            S_E_WAIT:
            begin
                cmd.rd_from = 1'b1;
                state_next  = S_D_A;
            end
            S_D_A:
            begin
                cmd.cap_du = 1'b1;
                cmd.rd_to  = 1'b1;
                state_next = S_D_B;
            end
            S_D_B:
            begin
                cmd.cap_dv = 1'b1;
                state_next = S_F_SUM;
            end
            S_F_SUM:
            begin
                cmd.fwd_sum = 1'b1;
                state_next  = S_F_UPD;
            end
            S_F_UPD:
            begin
                cmd.fwd_upd = 1'b1;
                state_next  = S_R_SUM;
            end
            S_R_SUM:
            begin
                cmd.rev_sum = 1'b1;
                state_next  = S_R_UPD;
            end
            S_R_UPD:
            begin
                cmd.rev_upd = 1'b1;
                if (e_reg == last_e)
                begin
                    e_next = '0;
                    if (pass_reg == n_m2)
                    begin
                        k_next     = '0;
                        state_next = S_O_RD;
                    end
                    else
                    begin
                        pass_next  = pass_reg + bfsp_pkg::V_W'(1);
                        state_next = S_E_RD;
                    end
                end
                else
                begin
                    e_next     = e_reg + bfsp_pkg::E_W'(1);
                    state_next = S_E_RD;
                end
            end
            S_O_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_O_CAP;
            end
            S_O_CAP:
            begin
                cmd.out_cap = 1'b1;
                state_next  = S_O_SEND;
            end
            S_O_SEND:
            begin
                if (out_ready)
                begin
                    if (k_reg == n_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + bfsp_pkg::V_W'(1);
                        state_next = S_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bellman_ford_shortest_paths_core.sv =====
// top level of the single-source shortest-path core
// depends on bfsp_pkg, bfsp_ctrl, bfsp_dpath (and through it bfsp_ram)
//
// Bellman-Ford shortest paths over an undirected weighted graph held in an
// on-chip edge store (MAX_EDGES entries of endpoints and weight). An add-edge
// item and a clear item are each taken while idle and give no result; an add
// to a full store is dropped. A run item first writes every distance entry as
// unreachable and the source as zero, then makes n-1 full passes over the edge
// store with no early exit (n the clamped vertex count). In each pass an edge
// is read from the edge store, its two endpoint distances are read one after
// the other through the single read port of the distance memory, and then a
// forward and a reverse relax follow, each a saturating add-and-compare
// followed by a write-back. Results then stream out, one per vertex in
// ascending order, with last on vertex n-1, each held until the sink is
// ready; no item is taken until the last result of a run is delivered.
// num_vertices is written through the cfg channel, which is always ready and
// must only be used while the core is idle.
module bellman_ford_shortest_paths_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfsp_pkg::CFG_W-1:0]         cfg_data,
    // item input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bfsp_pkg::OPC_W-1:0]         opcode,
    input  logic [bfsp_pkg::VID_W-1:0]         edge_from,
    input  logic [bfsp_pkg::VID_W-1:0]         edge_to,
    input  logic signed [bfsp_pkg::WIN_W-1:0]  edge_weight,
    input  logic [bfsp_pkg::VID_W-1:0]         source_vertex,
    // result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bfsp_pkg::VID_W-1:0]         vertex_index,
    output logic                               reachable,
    output logic signed [bfsp_pkg::DIST_W-1:0] distance,
    output logic                               last
);

    bfsp_pkg::bfsp_cmd_t  cmd;
    bfsp_pkg::bfsp_stat_t stat;
    logic                 in_ready_int;

    // register writes are accepted every cycle
    assign cfg_ready = 1'b1;
    assign in_ready  = in_ready_int;

    // sequencer: idle/accept, distance init, per-edge relax steps, result delivery
    bfsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready_int),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and arithmetic; commands are only issued for accepted items
    bfsp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr        (cfg_valid),
        .cfg_data      (cfg_data),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_weight   (edge_weight),
        .source_vertex (source_vertex),
        .vertex_index  (vertex_index),
        .reachable     (reachable),
        .distance      (distance),
        .last          (last)
    );

endmodule

// ===== dv/bfsp_path_checker.sv =====
// result checker for the shortest-path core: tracks the edge store and vertex count
// from the accepted items and config writes, predicts every run and compares results
// depends on bfsp_pkg
module bfsp_path_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bfsp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [bfsp_pkg::OPC_W-1:0]         opcode,
    input  logic [bfsp_pkg::VID_W-1:0]         edge_from,
    input  logic [bfsp_pkg::VID_W-1:0]         edge_to,
    input  logic signed [bfsp_pkg::WIN_W-1:0]  edge_weight,
    input  logic [bfsp_pkg::VID_W-1:0]         source_vertex,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [bfsp_pkg::VID_W-1:0]         vertex_index,
    input  logic                               reachable,
    input  logic signed [bfsp_pkg::DIST_W-1:0] distance,
    input  logic                               last,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DIST_MAX = 64'sd2147483647;
    localparam longint DIST_MIN = -64'sd2147483648;

    typedef struct {
        logic [bfsp_pkg::VID_W-1:0]         vid;
        logic                               reach;
        logic signed [bfsp_pkg::DIST_W-1:0] path_dist;
        logic                               last;
    } vertex_result_t;

    logic [bfsp_pkg::VID_W-1:0] edge_a [bfsp_pkg::MAX_EDGES];
    logic [bfsp_pkg::VID_W-1:0] edge_b [bfsp_pkg::MAX_EDGES];
    int                         edge_w [bfsp_pkg::MAX_EDGES];
    int                         edge_total;
    logic [bfsp_pkg::CFG_W-1:0] vertex_cfg;

    bit               reach_now [bfsp_pkg::MAX_VERTICES];
    int               dist_now  [bfsp_pkg::MAX_VERTICES];

    vertex_result_t   expected_dists [$];

    task automatic flag_mismatch(input string what);
        if (mismatches < 40)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void relax_edge(input int u, input int v, input int w, input int n);
        longint s;
        if (u >= n || v >= n || !reach_now[u])
            return;
        s = longint'(dist_now[u]) + longint'(w);
        if (s > DIST_MAX)
            s = DIST_MAX;
        if (s < DIST_MIN)
            s = DIST_MIN;
        if (!reach_now[v] || s < longint'(dist_now[v]))
        begin
            reach_now[v] = 1'b1;
            dist_now[v]  = int'(s);
        end
    endfunction

    // n-1 full passes, forward then reverse per edge, then one result per vertex
    function automatic void solve_paths(input logic [bfsp_pkg::VID_W-1:0] src);
        int n;
        vertex_result_t r;
        n = int'(vertex_cfg);
        if (n < 1)
            n = 1;
        if (n > bfsp_pkg::MAX_VERTICES)
            n = bfsp_pkg::MAX_VERTICES;
        for (int k = 0; k < n; k++)
        begin
            reach_now[k] = 1'b0;
            dist_now[k]  = 0;
        end
        if (int'(src) < n)
            reach_now[src] = 1'b1;
        for (int p = 0; p + 1 < n; p++)
        begin
            for (int e = 0; e < edge_total; e++)
            begin
                relax_edge(int'(edge_a[e]), int'(edge_b[e]), edge_w[e], n);
                relax_edge(int'(edge_b[e]), int'(edge_a[e]), edge_w[e], n);
            end
        end
        for (int k = 0; k < n; k++)
        begin
            r.vid       = bfsp_pkg::VID_W'(k);
            r.reach     = reach_now[k];
            r.path_dist = reach_now[k] ? dist_now[k] : -1;
            r.last      = (k + 1 == n);
            expected_dists = {expected_dists, r};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        vertex_result_t want;
        int w;
        if (!rst_n)
        begin
            edge_total = 0;
            vertex_cfg = bfsp_pkg::CFG_W'(bfsp_pkg::MAX_VERTICES);
            expected_dists.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vertex_cfg = cfg_data;

            if (out_valid && out_ready)
            begin
                if (expected_dists.size() == 0)
                begin
                    flag_mismatch($sformatf("result for vertex %0d with nothing expected",
                                            vertex_index));
                end
                else
                begin
                    want = expected_dists.pop_front();
                    if (vertex_index !== want.vid)
                        flag_mismatch($sformatf("vertex_index %0d, expected %0d",
                                                vertex_index, want.vid));
                    if (reachable !== want.reach)
                        flag_mismatch($sformatf("vertex %0d reachable %b, expected %b",
                                                want.vid, reachable, want.reach));
                    if (distance !== want.path_dist)
                        flag_mismatch($sformatf("vertex %0d distance %0d, expected %0d",
                                                want.vid, distance, want.path_dist));
                    if (last !== want.last)
                        flag_mismatch($sformatf("vertex %0d last %b, expected %b",
                                                want.vid, last, want.last));
                    results_checked++;
                end
            end

            if (in_valid && in_ready)
            begin
                case (opcode)
                    bfsp_pkg::OP_ADD:
                    begin
                        if (edge_total < bfsp_pkg::MAX_EDGES)
                        begin
                            // low WEIGHT_BITS bits, sign-extended
                            w = int'(edge_weight);
                            w = (w <<< (32 - bfsp_pkg::WEIGHT_BITS))
                                >>> (32 - bfsp_pkg::WEIGHT_BITS);
                            edge_a[edge_total] = edge_from;
                            edge_b[edge_total] = edge_to;
                            edge_w[edge_total] = w;
                            edge_total++;
                        end
                    end
                    bfsp_pkg::OP_RUN:
                        solve_paths(source_vertex);
                    bfsp_pkg::OP_CLR:
                        edge_total = 0;
                    default:
                        ;
                endcase
            end
            pending = expected_dists.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the shortest-path core testbench: clock, reset, item and config stimulus,
// result-side stalls and the final verdict
// depends on bfsp_pkg, bellman_ford_shortest_paths_core and bfsp_path_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode 3 has no meaning in the core and must be dropped silently
    localparam logic [bfsp_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [bfsp_pkg::CFG_W-1:0]           cfg_data      = '0;
    logic                                 in_valid      = 1'b0;
    logic                                 in_ready;
    logic [bfsp_pkg::OPC_W-1:0]           opcode        = bfsp_pkg::OP_CLR;
    logic [bfsp_pkg::VID_W-1:0]           edge_from     = '0;
    logic [bfsp_pkg::VID_W-1:0]           edge_to       = '0;
    logic signed [bfsp_pkg::WIN_W-1:0]    edge_weight   = '0;
    logic [bfsp_pkg::VID_W-1:0]           source_vertex = '0;
    logic                                 out_valid;
    logic                                 out_ready     = 1'b0;
    logic [bfsp_pkg::VID_W-1:0]           vertex_index;
    logic                                 reachable;
    logic signed [bfsp_pkg::DIST_W-1:0]   distance;
    logic                                 last;

    int mismatches;
    int pending;
    int results_checked;

    // stimulus bookkeeping
    int items_sent    = 0;
    int runs_sent     = 0;
    int ignored_sent  = 0;
    int edges_loaded  = 0;
    int burst_left    = 0;
    int hold_total    = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bellman_ford_shortest_paths_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_weight   (edge_weight),
        .source_vertex (source_vertex),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex_index  (vertex_index),
        .reachable     (reachable),
        .distance      (distance),
        .last          (last)
    );

    bfsp_path_checker path_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .edge_from       (edge_from),
        .edge_to         (edge_to),
        .edge_weight     (edge_weight),
        .source_vertex   (source_vertex),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .vertex_index    (vertex_index),
        .reachable       (reachable),
        .distance        (distance),
        .last            (last),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // ------------------------------------------------------------------
    // result side: stall pattern of its own, switching between modes
    // (always ready, coin toss, mostly stalled), plus one long hold-off
    // taken while a run is streaming and the next item is already waiting,
    // so the core has to back-pressure its input
    // ------------------------------------------------------------------
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  held_off   = 1'b0;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
            hold_total++;
        end
        else if (!held_off && out_valid && in_valid && !in_ready && results_checked > 100)
        begin
            held_off  = 1'b1;
            hold_left = 600;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // item side helpers
    // ------------------------------------------------------------------

    // one item, offered in bursts with random gaps; returns at the accepting edge
    // with valid still high, so back-to-back items never drop valid in between
    task automatic send_item(input logic [bfsp_pkg::OPC_W-1:0] op,
                             input logic [bfsp_pkg::VID_W-1:0] a,
                             input logic [bfsp_pkg::VID_W-1:0] b,
                             input logic signed [bfsp_pkg::WIN_W-1:0] w,
                             input logic [bfsp_pkg::VID_W-1:0] src);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid      <= 1'b1;
        opcode        <= op;
        edge_from     <= a;
        edge_to       <= b;
        edge_weight   <= w;
        source_vertex <= src;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_UNUSED)
            ignored_sent++;
        else
            items_sent++;
    endtask

    // unused fields of each item carry random bits
    task automatic add_edge(input logic [bfsp_pkg::VID_W-1:0] a,
                            input logic [bfsp_pkg::VID_W-1:0] b,
                            input logic signed [bfsp_pkg::WIN_W-1:0] w);
        send_item(bfsp_pkg::OP_ADD, a, b, w, bfsp_pkg::VID_W'($urandom));
        if (edges_loaded < bfsp_pkg::MAX_EDGES)
            edges_loaded++;
    endtask

    task automatic run_from(input logic [bfsp_pkg::VID_W-1:0] src);
        send_item(bfsp_pkg::OP_RUN, bfsp_pkg::VID_W'($urandom), bfsp_pkg::VID_W'($urandom),
                  bfsp_pkg::WIN_W'($urandom), src);
        runs_sent++;
    endtask

    task automatic clear_store();
        send_item(bfsp_pkg::OP_CLR, bfsp_pkg::VID_W'($urandom), bfsp_pkg::VID_W'($urandom),
                  bfsp_pkg::WIN_W'($urandom), bfsp_pkg::VID_W'($urandom));
        edges_loaded = 0;
    endtask

    task automatic junk_item();
        send_item(OP_UNUSED, bfsp_pkg::VID_W'($urandom), bfsp_pkg::VID_W'($urandom),
                  bfsp_pkg::WIN_W'($urandom), bfsp_pkg::VID_W'($urandom));
    endtask

    // drop valid, wait for the last expected result, then let the core settle
    // (an add or clear still in flight gives no result to wait for)
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // vertex count write; only called once the core is idle
    task automatic write_cfg(input logic [bfsp_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a vertex in use, now and then any 6-bit value
    function automatic logic [bfsp_pkg::VID_W-1:0] pick_vertex(input int n);
        if ($urandom_range(0, 7) == 0)
            return bfsp_pkg::VID_W'($urandom);
        return bfsp_pkg::VID_W'($urandom_range(0, n - 1));
    endfunction

    // mostly small positive weights, some negative, some at the extremes
    function automatic logic signed [bfsp_pkg::WIN_W-1:0] pick_weight();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return bfsp_pkg::WIN_W'($urandom);
            3:       return bfsp_pkg::WIN_W'(-int'($urandom_range(1, 100)));
            default: return bfsp_pkg::WIN_W'($urandom_range(1, 1000));
        endcase
    endfunction

    // register value: mostly small graphs, with zero, one, the maximum and
    // values above the maximum now and then
    function automatic logic [bfsp_pkg::CFG_W-1:0] pick_vertex_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return bfsp_pkg::CFG_W'(1);
            2:       return bfsp_pkg::CFG_W'(bfsp_pkg::MAX_VERTICES);
            3:       return bfsp_pkg::CFG_W'($urandom_range(bfsp_pkg::MAX_VERTICES + 1, 127));
            4, 5:    return bfsp_pkg::CFG_W'($urandom_range(13, bfsp_pkg::MAX_VERTICES - 1));
            default: return bfsp_pkg::CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [bfsp_pkg::CFG_W-1:0] n_raw;
        int n_eff;
        int cap;
        int phase;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset vertex count with an empty store, only the source reachable
        run_from(0);

        // single vertex; source in and out of range
        wait_idle();
        write_cfg(bfsp_pkg::CFG_W'(1));
        run_from(0);
        run_from(63);

        // six vertices, non-negative edges, one edge leaving the graph, a self-loop
        wait_idle();
        write_cfg(bfsp_pkg::CFG_W'(6));
        clear_store();
        add_edge(0, 1, 16'sd7);
        add_edge(1, 2, 16'sh7fff);
        add_edge(0, 2, 16'sd0);
        add_edge(3, 63, 16'sd5);
        add_edge(5, 5, 16'sd1);
        junk_item();
        run_from(0);
        run_from(5);
        run_from(6);
        run_from(63);

        // negative edges: every undirected negative edge is a negative cycle
        add_edge(2, 3, 16'sh8000);
        add_edge(63, 0, -16'sd1);
        run_from(1);

        // zero is taken as one vertex, anything above the maximum as the maximum
        wait_idle();
        write_cfg('0);
        run_from(0);
        wait_idle();
        write_cfg(bfsp_pkg::CFG_W'(127));
        run_from(3);

        // random phases: set a vertex count, usually clear, load a few edges,
        // then run from one or more sources; one phase fills the store past full
        phase = 0;
        while (items_sent < 430)
        begin
            if (phase == 2)
            begin
                wait_idle();
                write_cfg(bfsp_pkg::CFG_W'(3));
                clear_store();
                repeat (bfsp_pkg::MAX_EDGES + 6)
                    add_edge(pick_vertex(3), pick_vertex(3), pick_weight());
                run_from(pick_vertex(3));
                run_from(pick_vertex(3));
            end
            else
            begin
                n_raw = pick_vertex_count();
                wait_idle();
                write_cfg(n_raw);
                n_eff = int'(n_raw);
                if (n_eff < 1)
                    n_eff = 1;
                if (n_eff > bfsp_pkg::MAX_VERTICES)
                    n_eff = bfsp_pkg::MAX_VERTICES;
                // big graphs get few edges to keep runs short
                cap = (n_eff > 16) ? 6 : 14;
                if (edges_loaded > cap - 2 || $urandom_range(0, 3) != 0)
                    clear_store();
                repeat ($urandom_range(0, cap - edges_loaded))
                begin
                    add_edge(pick_vertex(n_eff), pick_vertex(n_eff), pick_weight());
                    if ($urandom_range(0, 19) == 0)
                        junk_item();
                end
                repeat ($urandom_range(1, 3))
                    run_from(pick_vertex(n_eff));
            end
            phase++;
        end

        // drain, then a little slack for anything still in flight
        wait_idle();
        repeat (40) @(negedge clk);

        $display("summary: %0d items (%0d runs) plus %0d unused-opcode items, %0d phases",
                 items_sent, runs_sent, ignored_sent, phase);
        $display("summary: %0d vertex results checked, %0d cycles of held-off results",
                 results_checked, hold_total);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // generous limit; a correct run finishes far sooner
    initial
    begin : watchdog
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
